>>> rtl/olsd_pkg.sv
// Shared types and constants for the ordered list store.
package olsd_pkg;

    // Default list depth and fixed field widths
    localparam int DepthDefault = 16;
    localparam int MaxResults   = 16;
    localparam int CmdW         = 3;
    localparam int ValW         = 32;
    localparam int StatusW      = 2;
    localparam int CountW       = 5;

    // Command codes
    localparam logic [CmdW-1:0] CMD_APPEND    = 3'd0;
    localparam logic [CmdW-1:0] CMD_DEL_HEAD  = 3'd1;
    localparam logic [CmdW-1:0] CMD_DEL_MATCH = 3'd2;
    localparam logic [CmdW-1:0] CMD_DEL_TAIL  = 3'd3;
    localparam logic [CmdW-1:0] CMD_DUMP      = 3'd4;

    // Status codes
    localparam logic [StatusW-1:0] ST_OK       = 2'd0;
    localparam logic [StatusW-1:0] ST_EMPTY    = 2'd1;
    localparam logic [StatusW-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [StatusW-1:0] ST_FULL     = 2'd3;

    // Input transaction
    typedef struct packed {
        logic [CmdW-1:0]        cmd;
        logic signed [ValW-1:0] value;
    } t_request;

    // Result transaction
    typedef struct packed {
        logic [StatusW-1:0]     status;
        logic signed [ValW-1:0] item;
        logic [CountW-1:0]      count;
        logic                   last;
    } t_result;

    // Controller to datapath commands
    typedef struct packed {
        logic            load;
        logic            search;
        logic            exec;
        logic            dump_step;
        logic [CmdW-1:0] op;
    } t_dp_ctl;

    // Datapath to controller status
    typedef struct packed {
        logic empty;
        logic dump_end;
    } t_dp_stat;

endpackage

>>> rtl/olsd_ctrl.sv
// Sequencing state machine for the ordered list store.
module olsd_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [olsd_pkg::CmdW-1:0]    i_cmd,
    input  olsd_pkg::t_dp_stat           i_stat,
    output olsd_pkg::t_dp_ctl            o_ctl,
    output logic                         o_busy
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_EXEC   = 4'b0100,
        S_DUMP   = 4'b1000
    } t_ctrl_state;

    t_ctrl_state                 r_state, n_state;
    logic [olsd_pkg::CmdW-1:0]   r_op, n_op;

    // Decide the next step and the datapath command
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        o_ctl       = '0;
        o_ctl.op    = r_op;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op       = i_cmd;
                    o_ctl.load = 1'b1;
                    if (i_cmd == olsd_pkg::CMD_DUMP && !i_stat.empty) begin
                        n_state = S_DUMP;
                    end else if (i_cmd == olsd_pkg::CMD_DEL_MATCH && !i_stat.empty) begin
                        n_state = S_SEARCH;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_SEARCH: begin
                o_ctl.search = 1'b1;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                o_ctl.exec = 1'b1;
                n_state    = S_IDLE;
            end
            S_DUMP: begin
                o_ctl.dump_step = 1'b1;
                if (i_stat.dump_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and the latched command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= olsd_pkg::CMD_APPEND;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // A search is always followed by its edit
    a_search_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SEARCH |=> r_state == S_EXEC)
        else $error("search not followed by edit");

    // Accepting a transaction always leaves idle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted transaction did not raise busy");

    // An edit is always followed by a return to idle
    a_exec_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |=> r_state == S_IDLE)
        else $error("edit did not return to idle");

endmodule

>>> rtl/olsd_dpath.sv
// Row of list cells with per-cell compare, shift, rotate and the result register.
module olsd_dpath #(
    parameter int DEPTH = olsd_pkg::DepthDefault
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [olsd_pkg::ValW-1:0]  i_value,
    input  olsd_pkg::t_dp_ctl                 i_ctl,
    output olsd_pkg::t_dp_stat                o_stat,
    output logic                              o_strobe,
    output olsd_pkg::t_result                 o_res
);

    localparam int OccW = $clog2(DEPTH + 1);
    localparam int IdxW = $clog2(DEPTH);

    logic [olsd_pkg::ValW-1:0]  r_cell [DEPTH];
    logic [olsd_pkg::ValW-1:0]  nxt    [DEPTH];
    logic [olsd_pkg::ValW-1:0]  r_val;
    logic [OccW-1:0]            r_occ, n_occ, occ_dec;
    logic [IdxW-1:0]            r_idx;
    logic [DEPTH-1:0]           r_match;
    logic                       r_strobe;
    olsd_pkg::t_result          r_res;

    logic                       empty, full, found;
    logic                       dump_end, dump_show, dump_last;
    logic [DEPTH-1:0]           low_bit, shift_mask;
    logic                       shift_en, do_append;
    logic [olsd_pkg::ValW-1:0]  tail_val;
    logic [olsd_pkg::StatusW-1:0] ex_status;
    logic [olsd_pkg::ValW-1:0]  ex_item;
    logic [31:0]                cnt_exec, cnt_dump, idx_wide;

    assign occ_dec = r_occ - OccW'(1);
    assign empty   = (r_occ == '0);
    assign full    = (r_occ == OccW'(DEPTH));

    // Pick the tail entry
    always_comb begin
        tail_val = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (OccW'(i) == occ_dec) begin
                tail_val = r_cell[i];
            end
        end
    end

    // Isolate the first match and mark it and every cell after it
    assign found      = |r_match;
    assign low_bit    = r_match & (~r_match + DEPTH'(1));
    assign shift_mask = ~(low_bit - DEPTH'(1));

    // Dump position
    assign idx_wide  = 32'(r_idx);
    assign dump_end  = (OccW'(r_idx) == occ_dec);
    assign dump_show = (idx_wide < 32'(olsd_pkg::MaxResults));
    assign dump_last = dump_end || (idx_wide == 32'(olsd_pkg::MaxResults - 1));

    assign o_stat.empty    = empty;
    assign o_stat.dump_end = dump_end;

    // Work out the edit and its result
    always_comb begin
        ex_status = olsd_pkg::ST_OK;
        ex_item   = '0;
        shift_en  = 1'b0;
        do_append = 1'b0;
        n_occ     = r_occ;
        case (i_ctl.op)
            olsd_pkg::CMD_APPEND: begin
                ex_item = r_val;
                if (full) begin
                    ex_status = olsd_pkg::ST_FULL;
                end else begin
                    do_append = 1'b1;
                    n_occ     = r_occ + OccW'(1);
                end
            end
            olsd_pkg::CMD_DEL_HEAD: begin
                if (empty) begin
                    ex_status = olsd_pkg::ST_EMPTY;
                end else begin
                    ex_item  = r_cell[0];
                    shift_en = 1'b1;
                    n_occ    = occ_dec;
                end
            end
            olsd_pkg::CMD_DEL_MATCH: begin
                ex_item = r_val;
                if (empty) begin
                    ex_status = olsd_pkg::ST_EMPTY;
                end else if (!found) begin
                    ex_status = olsd_pkg::ST_NOTFOUND;
                end else begin
                    shift_en = 1'b1;
                    n_occ    = occ_dec;
                end
            end
            olsd_pkg::CMD_DEL_TAIL: begin
                if (empty) begin
                    ex_status = olsd_pkg::ST_EMPTY;
                end else begin
                    ex_item = tail_val;
                    n_occ   = occ_dec;
                end
            end
            olsd_pkg::CMD_DUMP: begin
                ex_status = empty ? olsd_pkg::ST_EMPTY : olsd_pkg::ST_OK;
            end
            default: begin
                ex_status = olsd_pkg::ST_OK;
            end
        endcase
    end

    // Neighbour taps for shifting
    for (genvar g = 0; g < DEPTH; g++) begin : g_tap
        if (g < DEPTH - 1) begin : g_mid
            assign nxt[g] = r_cell[g + 1];
        end else begin : g_end
            assign nxt[g] = r_cell[g];
        end
    end

    // Update each cell: append, rotate during dump, or close the gap
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (i_ctl.exec && do_append && OccW'(g) == r_occ) begin
                r_cell[g] <= r_val;
            end else if (i_ctl.dump_step && OccW'(g) < r_occ) begin
                r_cell[g] <= (OccW'(g) == occ_dec) ? r_cell[0] : nxt[g];
            end else if (i_ctl.exec && shift_en
                         && (i_ctl.op == olsd_pkg::CMD_DEL_HEAD || shift_mask[g])) begin
                r_cell[g] <= nxt[g];
            end
        end
    end

    // Register per-cell matches against the searched value
    always_ff @(posedge i_clk) begin
        if (i_ctl.search) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_match[i] <= (r_cell[i] == r_val) && (OccW'(i) < r_occ);
            end
        end
    end

    // Latch the value and advance the dump position
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_val <= i_value;
            r_idx <= '0;
        end else if (i_ctl.dump_step) begin
            r_idx <= r_idx + IdxW'(1);
        end
    end

    // Occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_ctl.exec) begin
            r_occ <= n_occ;
        end
    end

    // Result register and strobe
    assign cnt_exec = 32'(n_occ);
    assign cnt_dump = 32'(r_occ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_ctl.exec || (i_ctl.dump_step && dump_show);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_res.status <= ex_status;
            r_res.item   <= ex_item;
            r_res.count  <= cnt_exec[olsd_pkg::CountW-1:0];
            r_res.last   <= 1'b1;
        end else if (i_ctl.dump_step) begin
            r_res.status <= olsd_pkg::ST_OK;
            r_res.item   <= r_cell[0];
            r_res.count  <= cnt_dump[olsd_pkg::CountW-1:0];
            r_res.last   <= dump_last;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // Occupancy never passes the depth
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OccW'(DEPTH))
        else $error("occupancy above depth");

    // Occupancy moves by at most one per transaction
    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_occ == $past(r_occ) || r_occ == $past(r_occ) + OccW'(1)
                            || r_occ == $past(r_occ) - OccW'(1)))
        else $error("occupancy jumped");

    // A dump leaves the occupancy alone
    a_dump_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.dump_step |=> $stable(r_occ))
        else $error("occupancy changed during dump");

endmodule

>>> rtl/ordered_list_store_with_deletion_top.sv
// Top level of the ordered list store: controller plus cell datapath.
//
// Holds an ordered list of up to DEPTH signed 32-bit values, empty after reset.
// Request channel: drive i_req and raise start; the transaction is taken at a
// clock edge where start is high and busy is low.
// Result channel: each result sits on o_res for exactly one cycle with
// o_strobe high; the receiver cannot stall, so results must be taken as shown.
// The result of an append, head or tail removal, an unknown command or a dump
// of an empty list is registered from the edit state after acceptance; removal
// of a matching value from a non-empty list first passes through the search
// state for the per-cell compare. A new transaction is taken only once the
// controller is back in idle. A dump holds busy while it streams the list one
// entry per cycle as the row rotates once through cell zero; at most 16
// results are given, the last one marked.
// Busy drops while the final result is still on the ports, so the next
// transaction can be accepted in that cycle.
// Reset (synchronous, active low) empties the list and clears the strobe.
module ordered_list_store_with_deletion_top #(
    parameter int DEPTH = olsd_pkg::DepthDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  olsd_pkg::t_request  i_req,
    output logic                o_strobe,
    output olsd_pkg::t_result   o_res
);

    olsd_pkg::t_dp_ctl  ctl;
    olsd_pkg::t_dp_stat stat;

    // Sequence each transaction
    olsd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_req.cmd),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    // Hold the list and form results
    olsd_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_value  (i_req.value),
        .i_ctl    (ctl),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

endmodule
